FILE: design/frust_pkg.sv
// ----------------------------------------------------------------------------
// frust_pkg
// shared types and constants of the six-plane frustum cull test
// ----------------------------------------------------------------------------
package frust_pkg;

    localparam int NUM_PLANES       = 6;
    localparam int PLANE_FIELD_BITS = 16;
    localparam int CFG_DATA_BITS    = 64;
    localparam int CFG_INDEX_BITS   = 3;
    localparam int NUM_AXES         = 3;

    typedef enum logic [1:0] {
        ACT_POINT  = 2'd0,
        ACT_SPHERE = 2'd1,
        ACT_BOX    = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        VERD_INSIDE    = 2'd0,
        VERD_INTERSECT = 2'd1,
        VERD_OUTSIDE   = 2'd2
    } t_verdict;

endpackage

FILE: design/frustum_cull_test.sv
// ----------------------------------------------------------------------------
// frustum_cull_test
// six-plane view frustum cull of points, spheres and axis-aligned boxes
// ----------------------------------------------------------------------------
// usage:
//   planes are written through i_cfg_we / i_cfg_index / i_cfg_wdata, one
//   64-bit register per plane (nx, ny, nz, w from the low field up); write
//   them only while no item is in flight
//   an item is taken at each clock edge with i_start high and o_busy low;
//   o_busy stays low, so an item may enter every cycle
//   each item yields one verdict on o_verdict with o_valid high for exactly
//   one cycle, once the item has passed the register stages named below
//   throughput is one item per cycle; each item passes through the six
//   register stages: input capture, centre/extent, per-plane multipliers,
//   distance sums, per-plane classification, plane priority combine
//   the receiver cannot stall, results are never held back
//   reset clears all planes to zero and drops every item in flight
// ----------------------------------------------------------------------------
module frustum_cull_test #(
    parameter int COORD_BITS       = 16,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_start,
    output logic                                     o_busy,
    input  logic [1:0]                               i_action,
    input  logic signed [COORD_BITS-1:0]             i_ax,
    input  logic signed [COORD_BITS-1:0]             i_ay,
    input  logic signed [COORD_BITS-1:0]             i_az,
    input  logic signed [COORD_BITS-1:0]             i_bx,
    input  logic signed [COORD_BITS-1:0]             i_by,
    input  logic signed [COORD_BITS-1:0]             i_bz,
    input  logic [COORD_BITS-2:0]                    i_radius,
    input  logic                                     i_cfg_we,
    input  logic [frust_pkg::CFG_INDEX_BITS-1:0]     i_cfg_index,
    input  logic [frust_pkg::CFG_DATA_BITS-1:0]      i_cfg_wdata,
    output logic                                     o_valid,
    output logic [1:0]                               o_verdict
);

    localparam int NP   = frust_pkg::NUM_PLANES;
    localparam int NA   = frust_pkg::NUM_AXES;
    localparam int FB   = frust_pkg::PLANE_FIELD_BITS;
    localparam int CEW  = COORD_BITS + 1;
    localparam int PW   = COORD_BITS + FB + 3;
    localparam int WTW  = FB + NORMAL_FRAC_BITS + 1;
    localparam int SW   = (PW > WTW) ? PW : WTW;
    localparam int DW   = SW + 2;
    localparam int RBW  = COORD_BITS + NORMAL_FRAC_BITS;
    localparam int CMPW = ((DW + 1 > RBW) ? DW + 1 : RBW) + 1;
    localparam int LATENCY = 6;

    logic accept;

    logic [frust_pkg::CFG_DATA_BITS-1:0] r_plane [NP];

    logic [5:0] r_vld;

    // stage 1: input capture
    logic [1:0]                   r_act1;
    logic signed [COORD_BITS-1:0] r_a1 [NA];
    logic signed [COORD_BITS-1:0] r_b1 [NA];
    logic [COORD_BITS-2:0]        r_rad1;

    // stage 2: centre and extent
    logic [1:0]            r_act2;
    logic signed [CEW-1:0] r_c2 [NA];
    logic signed [CEW-1:0] r_e2 [NA];
    logic [COORD_BITS-2:0] r_rad2;
    logic signed [CEW-1:0] n_c2 [NA];
    logic signed [CEW-1:0] n_e2 [NA];

    // stage 3: products
    logic [1:0]            r_act3;
    logic [COORD_BITS-2:0] r_rad3;
    logic signed [PW-1:0]  r_nc3 [NP][NA];
    logic signed [PW-1:0]  r_ne3 [NP][NA];
    logic signed [PW-1:0]  n_nc3 [NP][NA];
    logic signed [PW-1:0]  n_ne3 [NP][NA];

    // stage 4: distance and projected extent
    logic [1:0]            r_act4;
    logic [COORD_BITS-2:0] r_rad4;
    logic signed [DW-1:0]  r_d4 [NP];
    logic signed [DW-1:0]  r_r4 [NP];
    logic signed [DW-1:0]  n_d4 [NP];
    logic signed [DW-1:0]  n_r4 [NP];

    // stage 5: per-plane class
    logic [1:0]           r_act5;
    frust_pkg::t_verdict  r_cls5 [NP];
    frust_pkg::t_verdict  n_cls5 [NP];

    // stage 6: verdict
    logic [1:0] r_verdict;
    logic [1:0] n_verdict;

    assign o_busy  = 1'b0;
    assign accept  = i_start && !o_busy;
    assign o_valid = r_vld[5];
    assign o_verdict = r_verdict;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NP; p++) begin
                r_plane[p] <= '0;
            end
        end else if (i_cfg_we && (i_cfg_index < frust_pkg::CFG_INDEX_BITS'(NP))) begin
            r_plane[i_cfg_index] <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r_act1  <= i_action;
        r_a1[0] <= i_ax;
        r_a1[1] <= i_ay;
        r_a1[2] <= i_az;
        r_b1[0] <= i_bx;
        r_b1[1] <= i_by;
        r_b1[2] <= i_bz;
        r_rad1  <= i_radius;
    end

    always_comb begin
        for (int k = 0; k < NA; k++) begin
            if (r_act1 == frust_pkg::ACT_BOX) begin
                n_c2[k] = CEW'(r_a1[k]) + CEW'(r_b1[k]);
            end else begin
                n_c2[k] = CEW'(r_a1[k]);
            end
            n_e2[k] = CEW'(r_b1[k]) - CEW'(r_a1[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_act2 <= r_act1;
        r_rad2 <= r_rad1;
        r_c2   <= n_c2;
        r_e2   <= n_e2;
    end

    always_comb begin
        logic signed [FB-1:0] nv;
        logic signed [FB:0]   ext;
        logic [FB:0]          an;
        for (int p = 0; p < NP; p++) begin
            for (int k = 0; k < NA; k++) begin
                nv  = signed'(r_plane[p][FB*k +: FB]);
                ext = (FB+1)'(nv);
                an  = ext[FB] ? unsigned'(-ext) : unsigned'(ext);
                n_nc3[p][k] = PW'(nv) * PW'(r_c2[k]);
                n_ne3[p][k] = PW'(signed'({1'b0, an})) * PW'(r_e2[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_act3 <= r_act2;
        r_rad3 <= r_rad2;
        r_nc3  <= n_nc3;
        r_ne3  <= n_ne3;
    end

    always_comb begin
        logic signed [FB-1:0] wv;
        logic signed [DW-1:0] wterm;
        for (int p = 0; p < NP; p++) begin
            wv = signed'(r_plane[p][FB*NA +: FB]);
            if (r_act3 == frust_pkg::ACT_BOX) begin
                wterm = DW'(wv) <<< (NORMAL_FRAC_BITS + 1);
            end else begin
                wterm = DW'(wv) <<< NORMAL_FRAC_BITS;
            end
            n_d4[p] = DW'(r_nc3[p][0]) + DW'(r_nc3[p][1]) + DW'(r_nc3[p][2]) + wterm;
            n_r4[p] = DW'(r_ne3[p][0]) + DW'(r_ne3[p][1]) + DW'(r_ne3[p][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_act4 <= r_act3;
        r_rad4 <= r_rad3;
        r_d4   <= n_d4;
        r_r4   <= n_r4;
    end

    always_comb begin
        logic signed [CMPW-1:0] rbig;
        logic signed [CMPW-1:0] dext;
        logic signed [DW:0]     dpr;
        logic signed [DW:0]     dmr;
        rbig = signed'(CMPW'(r_rad4)) <<< NORMAL_FRAC_BITS;
        for (int p = 0; p < NP; p++) begin
            dext = CMPW'(r_d4[p]);
            dpr  = (DW+1)'(r_d4[p]) + (DW+1)'(r_r4[p]);
            dmr  = (DW+1)'(r_d4[p]) - (DW+1)'(r_r4[p]);
            case (r_act4)
                frust_pkg::ACT_POINT: begin
                    n_cls5[p] = r_d4[p][DW-1] ? frust_pkg::VERD_OUTSIDE
                                              : frust_pkg::VERD_INSIDE;
                end
                frust_pkg::ACT_SPHERE: begin
                    if (dext < -rbig) begin
                        n_cls5[p] = frust_pkg::VERD_OUTSIDE;
                    end else if (dext <= rbig) begin
                        n_cls5[p] = frust_pkg::VERD_INTERSECT;
                    end else begin
                        n_cls5[p] = frust_pkg::VERD_INSIDE;
                    end
                end
                frust_pkg::ACT_BOX: begin
                    if (dpr[DW]) begin
                        n_cls5[p] = frust_pkg::VERD_OUTSIDE;
                    end else if (dmr[DW]) begin
                        n_cls5[p] = frust_pkg::VERD_INTERSECT;
                    end else begin
                        n_cls5[p] = frust_pkg::VERD_INSIDE;
                    end
                end
                default: begin
                    n_cls5[p] = frust_pkg::VERD_INSIDE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_act5 <= r_act4;
        r_cls5 <= n_cls5;
    end

    always_comb begin
        logic any_out;
        logic any_isect;
        logic [1:0] first;
        any_out   = 1'b0;
        any_isect = 1'b0;
        first     = frust_pkg::VERD_INSIDE;
        // sphere walk stops at the lowest plane that is not inside
        for (int p = NP - 1; p >= 0; p--) begin
            if (r_cls5[p] != frust_pkg::VERD_INSIDE) begin
                first = r_cls5[p];
            end
        end
        for (int p = 0; p < NP; p++) begin
            any_out   = any_out   | (r_cls5[p] == frust_pkg::VERD_OUTSIDE);
            any_isect = any_isect | (r_cls5[p] == frust_pkg::VERD_INTERSECT);
        end
        case (r_act5)
            frust_pkg::ACT_SPHERE: begin
                n_verdict = first;
            end
            frust_pkg::ACT_POINT, frust_pkg::ACT_BOX: begin
                if (any_out) begin
                    n_verdict = frust_pkg::VERD_OUTSIDE;
                end else if (any_isect) begin
                    n_verdict = frust_pkg::VERD_INTERSECT;
                end else begin
                    n_verdict = frust_pkg::VERD_INSIDE;
                end
            end
            default: begin
                n_verdict = frust_pkg::VERD_INSIDE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_verdict <= n_verdict;
    end

`ifndef ASSERT_OFF
    a_result_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, LATENCY))
        else $error("result strobe without an item");

    a_item_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_valid)
        else $error("item produced no result");

    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_verdict != 2'd3))
        else $error("undefined verdict code");

    a_point_no_isect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && ($past(i_action, LATENCY) == frust_pkg::ACT_POINT)
        |-> (o_verdict != frust_pkg::VERD_INTERSECT))
        else $error("point test gave intersect");

    a_undef_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && ($past(i_action, LATENCY) == 2'd3)
        |-> (o_verdict == frust_pkg::VERD_INSIDE))
        else $error("undefined action not inside");
`endif

endmodule
